// ===== sv/csmv_pkg.sv =====
package csmv_pkg;

   // Operation codes carried on req_operation.
   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_NONZERO = 2'd1,
      OP_EMPTY   = 2'd2
   } op_type;

   localparam int OP_WIDTH    = 2;
   localparam int COL_WIDTH   = 12;
   localparam int VALUE_WIDTH = 32;
   localparam int SUM_WIDTH   = 64;
   localparam int ROW_WIDTH   = 16;

   // Decoupling queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = 2;
   localparam int QCNT_WIDTH  = 3;

   localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

   // One classified row item: a nonzero and its vector entry, or an empty row
   // (both operands zero).
   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] nz_value;
      logic signed [VALUE_WIDTH-1:0] vec_value;
      logic                          closes;
      logic                          last;
   } work_type;

endpackage

// ===== sv/csmv_front.sv =====
module csmv_front #(
   parameter int VECTOR_DEPTH = 4096
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [csmv_pkg::OP_WIDTH-1:0]          req_operation,
   input  logic [csmv_pkg::COL_WIDTH-1:0]         req_column_index,
   input  logic signed [csmv_pkg::VALUE_WIDTH-1:0] req_data_value,
   input  logic                                   req_end_of_row,
   input  logic                                   req_last_row,
   input  logic                                   q_full,
   output logic                                   q_push,
   output csmv_pkg::work_type                     q_item
);
   import csmv_pkg::*;

   localparam int ADDR_WIDTH = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
   localparam int EXT_WIDTH  = 17;

   logic [VALUE_WIDTH-1:0] vec_mem [VECTOR_DEPTH];

   logic                   accept;
   logic                   stage_adv;
   logic [EXT_WIDTH-1:0]   col_ext;
   logic                   in_range;
   logic [ADDR_WIDTH-1:0]  addr;
   logic                   is_load;
   logic                   is_row_item;
   logic                   closes_in;

   logic                   stage_vld_ff, stage_vld_in;
   logic signed [VALUE_WIDTH-1:0] nz_ff;
   logic                   col_ok_ff;
   logic                   closes_ff;
   logic                   last_ff;
   logic [VALUE_WIDTH-1:0] rd_ff;

   assign col_ext   = {{(EXT_WIDTH-COL_WIDTH){1'b0}}, req_column_index};
   assign in_range  = col_ext < EXT_WIDTH'(VECTOR_DEPTH);
   assign addr      = col_ext[ADDR_WIDTH-1:0];

   assign req_stall = stage_vld_ff & q_full;
   assign stage_adv = ~req_stall;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      is_load     = 1'b0;
      is_row_item = 1'b0;
      closes_in   = 1'b0;
      unique case (req_operation)
         OP_LOAD: begin
            is_load = 1'b1;
         end
         OP_NONZERO: begin
            is_row_item = 1'b1;
            closes_in   = req_end_of_row;
         end
         OP_EMPTY: begin
            is_row_item = 1'b1;
            closes_in   = 1'b1;
         end
         default: begin
            is_row_item = 1'b0;
         end
      endcase
   end

   always_comb begin
      stage_vld_in = stage_vld_ff;
      if (stage_adv) begin
         stage_vld_in = accept & is_row_item;
      end
   end

   // Vector store: written by loads, read by row items on acceptance.
   always_ff @(posedge clock) begin
      if (accept && is_load && in_range) begin
         vec_mem[addr] <= req_data_value;
      end
      if (accept && is_row_item) begin
         rd_ff <= vec_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= 1'b0;
      end else begin
         stage_vld_ff <= stage_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_row_item) begin
         // An empty row carries zero for both operands, so it adds nothing
         // whatever the store holds at its column.
         nz_ff     <= (req_operation == OP_NONZERO) ? req_data_value : '0;
         col_ok_ff <= in_range && (req_operation == OP_NONZERO);
         closes_ff <= closes_in;
         last_ff   <= req_last_row;
      end
   end

   assign q_push           = stage_vld_ff & ~q_full;
   assign q_item.nz_value  = nz_ff;
   assign q_item.vec_value = col_ok_ff ? $signed(rd_ff) : '0;
   assign q_item.closes    = closes_ff;
   assign q_item.last      = last_ff;

endmodule

// ===== sv/csmv_queue.sv =====
module csmv_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  csmv_pkg::work_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               pop_vld,
   output csmv_pkg::work_type pop_item
);
   import csmv_pkg::*;

   work_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]   count_ff, count_in;
   logic                    do_pop;

   assign full     = count_ff == QCNT_WIDTH'(QUEUE_DEPTH);
   assign pop_vld  = count_ff != '0;
   assign pop_item = entry_ff[rd_ptr_ff];
   assign do_pop   = pop & pop_vld;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== sv/csmv_back.sv =====
module csmv_back (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    q_vld,
   input  csmv_pkg::work_type                      q_item,
   output logic                                    q_pop,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [csmv_pkg::SUM_WIDTH-1:0]   rsp_row_sum,
   output logic [csmv_pkg::ROW_WIDTH-1:0]          rsp_row_number,
   output logic                                    rsp_final_row,
   output logic                                    rsp_saturated
);
   import csmv_pkg::*;

   logic adv;

   logic                        mul_vld_ff;
   logic signed [SUM_WIDTH-1:0] prod_ff, prod_in;
   logic                        closes_ff;
   logic                        last_ff;

   logic signed [SUM_WIDTH-1:0] acc_ff, acc_in;
   logic                        seen_ff, seen_in;
   logic [ROW_WIDTH-1:0]        row_ff, row_in;

   logic signed [SUM_WIDTH-1:0] sum_raw;
   logic                        ovf;
   logic signed [SUM_WIDTH-1:0] sum_sat;

   logic                        out_vld_ff, out_vld_in;
   logic signed [SUM_WIDTH-1:0] out_sum_ff;
   logic [ROW_WIDTH-1:0]        out_row_ff;
   logic                        out_final_ff;
   logic                        out_sat_ff;
   logic                        load_out;

   // The whole back end moves only while the result register can take an item.
   assign adv   = ~out_vld_ff | ~rsp_stall;
   assign q_pop = adv & q_vld;

   assign prod_in = q_item.nz_value * q_item.vec_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
      end else if (adv) begin
         mul_vld_ff <= q_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         prod_ff   <= prod_in;
         closes_ff <= q_item.closes;
         last_ff   <= q_item.last;
      end
   end

   // Saturating accumulate: overflow only when both addends share a sign
   // and the sum does not.
   assign sum_raw = acc_ff + prod_ff;
   assign ovf     = (acc_ff[SUM_WIDTH-1] == prod_ff[SUM_WIDTH-1])
                    && (sum_raw[SUM_WIDTH-1] != acc_ff[SUM_WIDTH-1]);
   assign sum_sat = ovf ? (acc_ff[SUM_WIDTH-1] ? SUM_MIN : SUM_MAX) : sum_raw;

   assign load_out = adv & mul_vld_ff & closes_ff;

   always_comb begin
      acc_in     = acc_ff;
      seen_in    = seen_ff;
      row_in     = row_ff;
      out_vld_in = out_vld_ff & rsp_stall;
      if (adv && mul_vld_ff) begin
         if (closes_ff) begin
            acc_in     = '0;
            seen_in    = 1'b0;
            row_in     = last_ff ? '0 : row_ff + 1'b1;
            out_vld_in = 1'b1;
         end else begin
            acc_in  = sum_sat;
            seen_in = seen_ff | ovf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         seen_ff    <= 1'b0;
         row_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         acc_ff     <= acc_in;
         seen_ff    <= seen_in;
         row_ff     <= row_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_sum_ff   <= sum_sat;
         out_row_ff   <= row_ff;
         out_final_ff <= last_ff;
         out_sat_ff   <= seen_ff | ovf;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_row_sum    = out_sum_ff;
   assign rsp_row_number = out_row_ff;
   assign rsp_final_row  = out_final_ff;
   assign rsp_saturated  = out_sat_ff;

endmodule

// ===== sv/csr_sparse_matrix_vector_multiply.sv =====
// Channel   | Direction | Handshake            | Payload
// req_      | in        | req_valid/req_stall  | operation, column_index, data_value,
//           |           |                      | end_of_row, last_row
// rsp_      | out       | rsp_valid/rsp_stall  | row_sum, row_number, final_row, saturated
//
// One item is taken every clock cycle while neither side stalls; the vector
// store's single write/read port and the one multiply-accumulate per cycle set
// that figure. rsp_valid rises once the closing item has gone through the front
// register, the queue and the multiplier register into the result register.
// Reset clears the accumulator, the row counter, the overflow flag and all valid
// state; the vector store is not cleared and must be loaded before use.
// A stalled result freezes the back end; the four-item queue keeps the front
// taking items until it is full and the front register holds a row item that
// cannot enter it, at which point req_stall is raised.
module csr_sparse_matrix_vector_multiply #(
   parameter int VECTOR_DEPTH = 4096
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [csmv_pkg::OP_WIDTH-1:0]           req_operation,
   input  logic [csmv_pkg::COL_WIDTH-1:0]          req_column_index,
   input  logic signed [csmv_pkg::VALUE_WIDTH-1:0] req_data_value,
   input  logic                                    req_end_of_row,
   input  logic                                    req_last_row,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [csmv_pkg::SUM_WIDTH-1:0]   rsp_row_sum,
   output logic [csmv_pkg::ROW_WIDTH-1:0]          rsp_row_number,
   output logic                                    rsp_final_row,
   output logic                                    rsp_saturated
);
   import csmv_pkg::*;

   // Front to queue.
   logic     q_full;
   logic     q_push;
   work_type push_item;

   // Queue to back.
   logic     q_pop;
   logic     q_vld;
   work_type pop_item;

   // The front decodes each item: loads go straight into the vector store,
   // nonzeros read their vector entry, and row items are queued.
   csmv_front #(
      .VECTOR_DEPTH (VECTOR_DEPTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_column_index (req_column_index),
      .req_data_value   (req_data_value),
      .req_end_of_row   (req_end_of_row),
      .req_last_row     (req_last_row),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_item           (push_item)
   );

   csmv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_vld   (q_vld),
      .pop_item  (pop_item)
   );

   // The back multiplies, accumulates with saturation and emits row results.
   csmv_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_vld          (q_vld),
      .q_item         (pop_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_row_sum    (rsp_row_sum),
      .rsp_row_number (rsp_row_number),
      .rsp_final_row  (rsp_final_row),
      .rsp_saturated  (rsp_saturated)
   );

endmodule

// ===== sv/csmv_checker.sv =====
module csmv_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_stall,
   input logic                                    rsp_valid,
   input logic                                    rsp_stall,
   input logic signed [csmv_pkg::SUM_WIDTH-1:0]   rsp_row_sum,
   input logic [csmv_pkg::ROW_WIDTH-1:0]          rsp_row_number,
   input logic                                    rsp_final_row,
   input logic                                    rsp_saturated
);
   import csmv_pkg::*;

   logic [ROW_WIDTH-1:0] exp_row_ff, exp_row_in;

   always_comb begin
      exp_row_in = exp_row_ff;
      if (rsp_valid && !rsp_stall) begin
         exp_row_in = rsp_final_row ? '0 : rsp_row_number + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_row_ff <= '0;
      end else begin
         exp_row_ff <= exp_row_in;
      end
   end

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result or stall present just after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_row_sum)
         && $stable(rsp_row_number) && $stable(rsp_saturated))
      else $error("stalled result changed");

   a_row_sequence: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_row_number == exp_row_ff)
      else $error("row number out of sequence");

endmodule

bind csr_sparse_matrix_vector_multiply csmv_checker u_csmv_checker (.*);
